// ===== rtl/gdad_pkg.sv =====
// gdad_pkg: calendar constants and month-length helpers for the
// Gregorian date-plus-days block. No dependencies.
package gdad_pkg;

  localparam int unsigned CycleYears = 400;
  localparam int unsigned RemBits    = 9;   // holds a year mod 400

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  localparam logic [RemBits-1:0] REM_LAST = RemBits'(CycleYears - 1);

  // floor(x / 25) == (x * RECIP_25) >> RECIP_25_SHIFT for any x below 2^28
  localparam logic [28:0]  RECIP_25       = 29'd343597384;
  localparam int unsigned  RECIP_25_SHIFT = 33;

  // Leap year from the year's remainder mod 400.
  function automatic logic is_leap(input logic [RemBits-1:0] rem);
    logic cent;
    cent = (rem == RemBits'(100)) || (rem == RemBits'(200)) || (rem == RemBits'(300));
    return (rem[1:0] == 2'd0) && !cent;
  endfunction

  // Days in a month; any code outside 1..12 counts as 30.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      MONTH_FEB:                      len = leap ? 5'd29 : 5'd28;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8,
      4'd10, MONTH_DEC:               len = 5'd31;
      default:                        len = 5'd30;
    endcase
    return len;
  endfunction

  function automatic logic month_ok(input logic [3:0] m);
    return (m >= MONTH_JAN) && (m <= MONTH_DEC);
  endfunction

endpackage

// ===== rtl/gdad_alu.sv =====
// gdad_alu: subtract/compare unit used by the date sequencer.
// No package dependencies.
module gdad_alu #(
  parameter int unsigned DW = 17
) (
  input  logic [DW-1:0] a,
  input  logic [DW-1:0] b,
  output logic [DW-1:0] diff,
  output logic          ge
);

  logic [DW:0] full;

  assign full = {1'b0, a} - {1'b0, b};
  assign diff = full[DW-1:0];
  assign ge   = !full[DW];   // no borrow: a >= b

endmodule

// ===== rtl/gregorian_date_add_days.sv =====
// gregorian_date_add_days: validates a date, adds a day offset and rolls
// forward month by month. Depends on gdad_pkg and gdad_alu.
//
//  channel | dir | handshake                    | word
//  --------+-----+------------------------------+---------------------------------
//  s_axis  | in  | s_axis_tvalid/s_axis_tready  | day_in, month_in, year_in, days_to_add
//  m_axis  | out | m_axis_tvalid/m_axis_tready  | day_out, month_out, year_out;
//          |     |                              | tuser = year_overflow
//
// Steps per word: capture, year / 400 by reciprocal multiply, year mod 400,
//   validate, one month step per month stepped, then result load.
//   Months stepped is about (day + days_to_add) / 30.4, so the month-step loop
//   through the single subtract/compare unit dominates for a long offset.
// s_axis_tready is high only while the sequencer is idle; one word is in flight.
// The result sits in an output register; a new word is taken while it waits,
//   and the sequencer holds its last step until the register is free.
// rst is synchronous, active high; it clears the sequencer and output valid.
module gregorian_date_add_days #(
  parameter int unsigned YEAR_BITS   = 14,
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // [7:0] day_in, [11:8] month_in, then year_in, then days_to_add, zero pad
  input  logic [((12 + YEAR_BITS + OFFSET_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // [4:0] day_out, [8:5] month_out, then year_out, zero pad
  output logic [((9 + YEAR_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // [0] year_overflow
  output logic m_axis_tuser
);

  import gdad_pkg::*;

  localparam int unsigned OUT_W  = ((9 + YEAR_BITS + 7) / 8) * 8;
  localparam int unsigned SUM_W  = ((OFFSET_BITS > 8) ? OFFSET_BITS : 8) + 1;
  localparam int unsigned DW     = SUM_W;
  localparam int unsigned HI_W   = YEAR_BITS - 3;   // year / 16 with a spare top bit
  localparam int unsigned PROD_W = HI_W + $bits(RECIP_25);

  typedef enum logic [2:0] {ST_IDLE, ST_MOD, ST_REM, ST_VALID, ST_STEP} state_t;

  state_t                 state;
  logic [7:0]             day;
  logic [3:0]             mon;
  logic [YEAR_BITS-1:0]   yr;
  logic [OFFSET_BITS-1:0] add;
  logic [DW-1:0]          nd;
  logic [RemBits-1:0]     rem;
  logic [HI_W-1:0]        quot;     // year / 400
  logic                   ovf;

  logic                   out_valid;
  logic [4:0]             out_day;
  logic [3:0]             out_mon;
  logic [YEAR_BITS-1:0]   out_yr;
  logic                   out_ovf;

  logic [DW-1:0] alu_a, alu_b, alu_diff;
  logic          alu_ge;
  logic          leap;
  logic [4:0]    cur_len;
  logic          more;      // day still past end of month
  logic          out_free;
  logic          out_load;
  logic [YEAR_BITS:0] yr_inc;
  logic [7:0]    day_ok;
  logic [HI_W-1:0]   yr_hi;
  logic [PROD_W-1:0] prod;
  logic [HI_W-1:0]   q25;
  logic [HI_W-1:0]   hi_rem;

  assign leap     = is_leap(rem);
  assign cur_len  = month_len(mon, leap);
  assign more     = alu_ge && (alu_diff != '0);
  assign out_free = !out_valid || m_axis_tready;
  assign out_load = (state == ST_STEP) && !more && out_free;
  assign yr_inc   = {1'b0, yr} + (YEAR_BITS + 1)'(1);
  assign day_ok   = ((day != 8'd0) && (day <= {3'd0, cur_len})) ? day : 8'd0;

  // year mod 400 = (year / 16 mod 25) * 16 + year[3:0]
  assign yr_hi  = {1'b0, yr[YEAR_BITS-1:4]};
  assign prod   = PROD_W'(yr_hi) * PROD_W'(RECIP_25);
  assign q25    = (quot << 4) + (quot << 3) + quot;   // quot * 25
  assign hi_rem = yr_hi - q25;

  // One unit: month steps during ST_STEP.
  assign alu_a = nd;
  assign alu_b = DW'(cur_len);

  gdad_alu #(.DW(DW)) u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .diff (alu_diff),
    .ge   (alu_ge)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            day   <= s_axis_tdata[7:0];
            mon   <= s_axis_tdata[11:8];
            yr    <= s_axis_tdata[12 +: YEAR_BITS];
            add   <= s_axis_tdata[12 + YEAR_BITS +: OFFSET_BITS];
            ovf   <= 1'b0;
            state <= ST_MOD;
          end
        end
        ST_MOD: begin
          quot  <= HI_W'(prod >> RECIP_25_SHIFT);
          state <= ST_REM;
        end
        ST_REM: begin
          rem   <= {hi_rem[4:0], yr[3:0]};
          state <= ST_VALID;
        end
        ST_VALID: begin
          // day checked against the raw month; bad month then becomes 0
          mon   <= month_ok(mon) ? mon : 4'd0;
          nd    <= DW'(day_ok) + DW'(add);
          state <= ST_STEP;
        end
        ST_STEP: begin
          if (more) begin
            nd <= alu_diff;
            if (mon == MONTH_DEC) begin
              mon <= MONTH_JAN;
              yr  <= yr_inc[YEAR_BITS-1:0];
              ovf <= ovf | yr_inc[YEAR_BITS];
              rem <= (rem == REM_LAST) ? '0 : rem + RemBits'(1);
            end else begin
              mon <= mon + 4'd1;
            end
          end else if (out_free) begin
            out_ovf   <= ovf;
            out_day   <= ovf ? 5'd0 : nd[4:0];
            out_mon   <= ovf ? 4'd0 : mon;
            out_yr    <= ovf ? '0 : yr;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_ovf;
  assign m_axis_tdata  = OUT_W'({out_yr, out_mon, out_day});

  // Overflowed results carry an all-zero date.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("overflow result with nonzero date");

  // Result month is 0..12.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[8:5] <= MONTH_DEC))
    else $error("result month out of range");

  // Year remainder stays below 400 once computed.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_STEP) |-> (rem <= REM_LAST))
    else $error("year remainder out of range");

  // A finished step with a free output register loads it and returns to idle.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_STEP && !more && out_free) |=> (state == ST_IDLE && out_valid))
    else $error("finished word not delivered");

  // The remainder comes from the multiply state followed by the reduce state.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_MOD) |=> (state == ST_REM))
    else $error("remainder sequence out of order");

endmodule

// ===== sim/tb_top.sv =====
// tb_top: self-checking bench for gregorian_date_add_days. Drives date words
// on s_axis and checks every m_axis word against an in-bench calendar predictor.
// Depends on gdad_pkg and the gregorian_date_add_days RTL.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gdad_pkg::*;

  localparam int unsigned YB        = 14;
  localparam int unsigned OB        = 16;
  localparam int unsigned IN_W      = ((12 + YB + OB + 7) / 8) * 8;
  localparam int unsigned OUT_W     = ((9 + YB + 7) / 8) * 8;
  localparam int unsigned YEAR_MAX  = (1 << YB) - 1;
  localparam int unsigned OFS_MAX   = (1 << OB) - 1;

  // Month codes not exported by the package (30-day months).
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd11;
  localparam logic [3:0] MONTH_BAD = 4'd15;

  localparam int unsigned RandomWords = 252;
  localparam int unsigned SmallFirst  = 80;    // random words with short offsets first
  localparam int unsigned PressureAt  = 60;    // results seen before the long hold-off
  localparam int unsigned LongHold    = 600;   // receiver hold-off, cycles
  localparam int unsigned DrainCycles = 64;    // quiet cycles after the last result
  localparam int unsigned IdleLimit   = 20000; // no handshake for this long = hang
  localparam int unsigned PrintLimit  = 40;

  typedef struct packed {
    logic [7:0]    day;
    logic [3:0]    month;
    logic [YB-1:0] year;
    logic [OB-1:0] offset;
  } date_word_t;

  typedef struct packed {
    logic [4:0]    day;
    logic [3:0]    month;
    logic [YB-1:0] year;
    logic          overflow;
  } sum_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic m_axis_tuser;

  gregorian_date_add_days #(
    .YEAR_BITS  (YB),
    .OFFSET_BITS(OB)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // [7:0] day, [11:8] month, year, days_to_add, pad
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // [4:0] day, [8:5] month, year, pad
    .m_axis_tuser (m_axis_tuser)    // [0] year_overflow
  );

  // Bench state
  date_word_t  dates_to_send[$];   // words not yet offered
  sum_word_t   sums_due[$];        // predicted results in word order
  date_word_t  cur_date = '0;      // word currently on s_axis
  date_word_t  next_date;
  sum_word_t   want;
  logic        in_fire = 1'b0;     // word accepted at the last rising edge
  logic        out_fire = 1'b0;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;
  int unsigned rx_draw;
  int unsigned hold_left = 0;
  logic        held_once = 1'b0;
  int unsigned n_sent = 0;
  int unsigned n_got = 0;
  int unsigned n_err = 0;
  int unsigned idle_cycles = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------------
  function automatic logic leap_year(input int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  // Anything outside 1..12 (including the cleared month 0) lasts 30 days.
  function automatic int unsigned days_in(input int unsigned m, input int unsigned y);
    int unsigned len;
    case (m)
      MONTH_FEB:                                  len = leap_year(y) ? 29 : 28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 30;
      default:                                    len = (m >= MONTH_JAN && m <= MONTH_DEC) ? 31 : 30;
    endcase
    return len;
  endfunction

  // Validate, add the offset, roll forward month by month. The year may run
  // past YEAR_MAX here; that is the overflow case.
  function automatic sum_word_t add_days(input date_word_t w);
    int unsigned yr;
    int unsigned mo;
    int unsigned dd;
    sum_word_t   r;
    yr = w.year;
    mo = (w.month >= MONTH_JAN && w.month <= MONTH_DEC) ? w.month : 0;
    // day is checked against the raw month, so a bad month still allows 1..30
    dd = (w.day >= 1 && w.day <= days_in(w.month, yr)) ? w.day : 0;
    dd = dd + w.offset;
    while (dd > days_in(mo, yr)) begin
      dd = dd - days_in(mo, yr);
      mo = mo + 1;
      if (mo > MONTH_DEC) begin
        mo = MONTH_JAN;
        yr = yr + 1;
      end
    end
    r = '0;
    if (yr > YEAR_MAX) begin
      r.overflow = 1'b1;
    end else begin
      r.day   = 5'(dd);   // dd == 0 only when an invalid day got no offset
      r.month = 4'(mo);
      r.year  = YB'(yr);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_date(input int unsigned d, input int unsigned m,
                            input int unsigned y, input int unsigned ofs);
    date_word_t w;
    w.day    = 8'(d);
    w.month  = 4'(m);
    w.year   = YB'(y);
    w.offset = OB'(ofs);
    dates_to_send.push_back(w);
  endtask

  // Mostly well-formed dates with random content; the rest is raw noise on
  // day, month and year. Early words keep offsets short so the pipe turns over fast.
  function automatic date_word_t random_date(input int unsigned idx);
    date_word_t w;
    if ($urandom_range(0, 99) < 70) begin
      w.month = 4'($urandom_range(MONTH_JAN, MONTH_DEC));
      if ($urandom_range(0, 9) == 0)
        w.year = YB'($urandom_range(YEAR_MAX - 300, YEAR_MAX));
      else
        w.year = YB'($urandom_range(0, YEAR_MAX));
      w.day = 8'($urandom_range(1, days_in(w.month, w.year)));
    end else begin
      w.day   = 8'($urandom_range(0, 255));
      w.month = 4'($urandom_range(0, MONTH_BAD));
      w.year  = YB'($urandom_range(0, YEAR_MAX));
    end
    if (idx < SmallFirst)
      w.offset = OB'($urandom_range(0, 400));
    else if ($urandom_range(0, 99) < 15)
      w.offset = OB'($urandom_range(0, OFS_MAX));
    else
      w.offset = OB'($urandom_range(0, 2000));
    return w;
  endfunction

  function automatic int unsigned draw_gap(input logic calm);
    return calm ? 0 : $urandom_range(0, 9);
  endfunction

  task automatic report(input string what, input int unsigned exp_v, input int unsigned got_v);
    if (n_err < PrintLimit)
      $display("[%0t] result %0d: %s expected %0d got %0d", $realtime, n_got, what, exp_v, got_v);
    n_err++;
  endtask

  initial begin
    // directed corners
    queue_date(1, MONTH_JAN, 0, 0);               // year zero
    queue_date(29, MONTH_FEB, 0, 0);              // year zero is leap
    queue_date(29, MONTH_FEB, 1900, 0);           // century, not leap: day cleared
    queue_date(29, MONTH_FEB, 2000, 1);           // 400-year leap, roll into March
    queue_date(28, MONTH_FEB, 2023, 1);
    queue_date(31, MONTH_APR, 2001, 0);           // day past month end
    queue_date(0, 5, 2023, 0);                    // day zero stays zero
    queue_date(255, MONTH_JAN, 1, 0);             // widest day value
    queue_date(0, 0, 0, 0);                       // all zero
    queue_date(15, 13, 2020, 10);                 // bad month, no rollover
    queue_date(30, 0, 5, 1);                      // month 0 rolls into January
    queue_date(255, MONTH_BAD, YEAR_MAX, OFS_MAX);// every input bit set
    queue_date(31, MONTH_JAN, 2001, 30);
    queue_date(1, MONTH_JAN, YEAR_MAX, 364);      // last day of the last year
    queue_date(31, MONTH_DEC, YEAR_MAX, 0);
    queue_date(31, MONTH_DEC, YEAR_MAX, 1);       // year overflow
    queue_date(31, MONTH_DEC, YEAR_MAX - 183, OFS_MAX); // long walk that stays below YEAR_MAX
    queue_date(1, MONTH_JAN, 2024, OFS_MAX);      // long walk with the maximum offset
    queue_date(31, MONTH_DEC, 16000, OFS_MAX);
    for (int unsigned i = 0; i < RandomWords; i++)
      dates_to_send.push_back(random_date(i));

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // all words offered and taken, every prediction compared
    while (dates_to_send.size() != 0 || s_axis_tvalid || sums_due.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (n_err == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sender: one word per handshake, random gap after each, calm stretches
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      in_gap        <= 0;
    end else if (in_fire || !s_axis_tvalid) begin
      if (in_gap != 0) begin
        s_axis_tvalid <= 1'b0;
        in_gap        <= in_gap - 1;
      end else if (dates_to_send.size() != 0) begin
        next_date = dates_to_send.pop_front();
        cur_date      <= next_date;
        s_axis_tdata  <= IN_W'({next_date.offset, next_date.year, next_date.month,
                                next_date.day});
        s_axis_tvalid <= 1'b1;
        in_gap        <= draw_gap((n_sent / 40) % 4 == 2);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall after each result, one long hold-off so the block
  // fills (output register plus one word in flight) and drops s_axis_tready
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      out_gap       <= 0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (!held_once && n_got >= PressureAt) begin
      m_axis_tready <= 1'b0;
      held_once     <= 1'b1;
      hold_left     <= LongHold;
    end else if (out_fire) begin
      rx_draw = draw_gap((n_got / 40) % 4 == 1);
      out_gap       <= rx_draw;
      m_axis_tready <= (rx_draw == 0);
    end else if (out_gap != 0) begin
      out_gap       <= out_gap - 1;
      m_axis_tready <= (out_gap == 1);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on input handshake, compare on output handshake
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    in_fire  <= !rst && s_axis_tvalid && s_axis_tready;
    out_fire <= !rst && m_axis_tvalid && m_axis_tready;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      sums_due.push_back(add_days(cur_date));
      n_sent <= n_sent + 1;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      n_got <= n_got + 1;
      if (sums_due.size() == 0) begin
        report("unexpected word, day", 0, m_axis_tdata[4:0]);
      end else begin
        want = sums_due.pop_front();
        if (m_axis_tdata[4:0] !== want.day)
          report("day_out", want.day, m_axis_tdata[4:0]);
        if (m_axis_tdata[8:5] !== want.month)
          report("month_out", want.month, m_axis_tdata[8:5]);
        if (m_axis_tdata[9 +: YB] !== want.year)
          report("year_out", want.year, m_axis_tdata[9 +: YB]);
        if (m_axis_tuser !== want.overflow)
          report("year_overflow", want.overflow, m_axis_tuser);
      end
    end
  end

  // Hang detector: no handshake on either side for IdleLimit cycles.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("timeout: %0d words sent, %0d results, %0d pending", n_sent, n_got,
               sums_due.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
rtl/gdad_pkg.sv
rtl/gdad_alu.sv
rtl/gregorian_date_add_days.sv
sim/tb_top.sv
